>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion violated");

`else

`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/dsmm_pkg.sv
// ---------------------------------------------------------------------------
// Disjoint-set min/max package
// Table geometry, opcodes and the entry and write-request types.
// ---------------------------------------------------------------------------
package dsmm_pkg;

  // Table geometry.
  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;

  // Union by size keeps every path no longer than the index width.
  localparam int PATH_DEPTH   = IDX_W;
  localparam int PATH_IDX_W   = $clog2(PATH_DEPTH);
  localparam int PATH_CNT_W   = $clog2(PATH_DEPTH + 1);

  // Opcodes; the unused code behaves as a query.
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_UNITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // One table entry. Count, low and high are meaningful at roots only.
  typedef struct packed {
    logic [IDX_W-1:0] parent;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] low;
    logic [IDX_W-1:0] high;
  } entry_t;

  // Write request to the table memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

>>> hdl/disjoint_set_min_max_unit.sv
// ---------------------------------------------------------------------------
// Disjoint-set union-find unit with set minimum and maximum
// A query or unite walks x and y to their roots and compresses each path; a merging unite
// then writes the losing and winning roots. Paths are at most 10 links long.
// The table memory read port walks one link a cycle and its write port takes one
// compression or merge write a cycle. A clear reruns the sweep over all 1024 entries.
// After reset that sweep runs before the first input; a new item is taken only once the last result is loaded.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module disjoint_set_min_max_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [dsmm_pkg::IDX_W-1:0]  in_elem_x,
  input  logic [dsmm_pkg::IDX_W-1:0]  in_elem_y,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dsmm_pkg::IDX_W-1:0]  out_root_x,
  output logic [dsmm_pkg::IDX_W-1:0]  out_root_y,
  output logic                        out_same_set,
  output logic [dsmm_pkg::IDX_W-1:0]  out_set_min,
  output logic [dsmm_pkg::IDX_W-1:0]  out_set_max,
  output logic [dsmm_pkg::CNT_W-1:0]  out_set_size
);

  localparam int IDX_W      = dsmm_pkg::IDX_W;
  localparam int CNT_W      = dsmm_pkg::CNT_W;
  localparam int PATH_DEPTH = dsmm_pkg::PATH_DEPTH;
  localparam int PATH_IDX_W = dsmm_pkg::PATH_IDX_W;
  localparam int PATH_CNT_W = dsmm_pkg::PATH_CNT_W;

  typedef enum logic [6:0] {
    ST_SWEEP      = 7'b0000001,
    ST_IDLE       = 7'b0000010,
    ST_CHECK      = 7'b0000100,
    ST_COMPRESS   = 7'b0001000,
    ST_MERGE_LOSE = 7'b0010000,
    ST_MERGE_WIN  = 7'b0100000,
    ST_RESULT     = 7'b1000000
  } state_t;

  // Control registers
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic                   sweep_clear_r, sweep_clear_nxt;
  logic                   out_valid_r;

  // Item and walk registers
  logic [1:0]             op_r, op_nxt;
  logic [IDX_W-1:0]       x_r, x_nxt;
  logic [IDX_W-1:0]       y_r, y_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic                   phase_y_r, phase_y_nxt;
  logic [PATH_CNT_W-1:0]  path_cnt_r, path_cnt_nxt;
  logic [PATH_IDX_W-1:0]  comp_idx_r, comp_idx_nxt;
  logic [IDX_W-1:0]       path_r [PATH_DEPTH];
  logic [IDX_W-1:0]       rx_r, rx_nxt;
  logic [IDX_W-1:0]       ry_r, ry_nxt;
  dsmm_pkg::entry_t       info_x_r, info_x_nxt;
  dsmm_pkg::entry_t       info_y_r, info_y_nxt;

  // Output payload registers
  logic [IDX_W-1:0]       out_root_x_r, out_root_y_r, out_set_min_r, out_set_max_r;
  logic                   out_same_set_r;
  logic [CNT_W-1:0]       out_set_size_r;

  // Memory interface and combinational helpers
  dsmm_pkg::wr_req_t      wr_req;
  logic [IDX_W-1:0]       rd_addr;
  dsmm_pkg::entry_t       rd_data;
  logic                   path_push;
  logic                   find_done;
  logic                   out_load;
  logic [IDX_W-1:0]       end_root;
  logic                   do_merge;
  logic                   win_is_y;
  logic [IDX_W-1:0]       win_idx, lose_idx;
  logic [CNT_W-1:0]       merged_count;
  logic [IDX_W-1:0]       merged_low, merged_high;
  logic [IDX_W-1:0]       res_root_x, res_root_y, res_min, res_max;
  logic                   res_same;
  logic [CNT_W-1:0]       res_size;

  dsmm_table u_table (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Merge arithmetic: the larger set's root wins, x's root on a tie.
  assign win_is_y     = info_x_r.count < info_y_r.count;
  assign win_idx      = win_is_y ? ry_r : rx_r;
  assign lose_idx     = win_is_y ? rx_r : ry_r;
  assign merged_count = info_x_r.count + info_y_r.count;
  assign merged_low   = (info_y_r.low < info_x_r.low) ? info_y_r.low : info_x_r.low;
  assign merged_high  = (info_y_r.high > info_x_r.high) ? info_y_r.high : info_x_r.high;
  assign do_merge     = (op_r == dsmm_pkg::OP_UNITE) && (rx_r != ry_r);

  // Root of the find that is finishing now; in the check state it is not yet stored.
  assign end_root = (state_r == ST_CHECK) ? cur_r : (phase_y_r ? ry_r : rx_r);

  // Result selection for the item in hand.
  always_comb begin
    if (op_r == dsmm_pkg::OP_CLEAR) begin
      res_root_x = x_r;
      res_root_y = y_r;
      res_same   = (x_r == y_r);
      res_min    = x_r;
      res_max    = x_r;
      res_size   = CNT_W'(1);
    end else if (do_merge) begin
      res_root_x = win_idx;
      res_root_y = win_idx;
      res_same   = 1'b1;
      res_min    = merged_low;
      res_max    = merged_high;
      res_size   = merged_count;
    end else begin
      res_root_x = rx_r;
      res_root_y = ry_r;
      res_same   = (rx_r == ry_r);
      res_min    = info_x_r.low;
      res_max    = info_x_r.high;
      res_size   = info_x_r.count;
    end
  end

  // Sequencer: sweep, walk to the root, compress, merge, deliver.
  always_comb begin
    state_nxt       = state_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    sweep_clear_nxt = sweep_clear_r;
    op_nxt          = op_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    cur_nxt         = cur_r;
    phase_y_nxt     = phase_y_r;
    path_cnt_nxt    = path_cnt_r;
    comp_idx_nxt    = comp_idx_r;
    rx_nxt          = rx_r;
    ry_nxt          = ry_r;
    info_x_nxt      = info_x_r;
    info_y_nxt      = info_y_r;
    wr_req          = '0;
    rd_addr         = cur_r;
    path_push       = 1'b0;
    find_done       = 1'b0;
    out_load        = 1'b0;

    unique case (state_r)
      ST_SWEEP: begin
        // Restore one singleton entry per cycle.
        wr_req.en          = 1'b1;
        wr_req.addr        = sweep_cnt_r;
        wr_req.data.parent = sweep_cnt_r;
        wr_req.data.count  = CNT_W'(1);
        wr_req.data.low    = sweep_cnt_r;
        wr_req.data.high   = sweep_cnt_r;
        sweep_cnt_nxt      = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == IDX_W'(dsmm_pkg::NUM_ELEMENTS - 1)) begin
          sweep_cnt_nxt   = '0;
          sweep_clear_nxt = 1'b0;
          state_nxt       = sweep_clear_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          x_nxt  = in_elem_x;
          y_nxt  = in_elem_y;
          if (in_opcode == dsmm_pkg::OP_CLEAR) begin
            sweep_clear_nxt = 1'b1;
            state_nxt       = ST_SWEEP;
          end else begin
            rd_addr      = in_elem_x;
            cur_nxt      = in_elem_x;
            path_cnt_nxt = '0;
            phase_y_nxt  = 1'b0;
            state_nxt    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (rd_data.parent == cur_r) begin
          // Root reached: keep its entry for the merge and the result.
          if (phase_y_r) begin
            ry_nxt     = cur_r;
            info_y_nxt = rd_data;
          end else begin
            rx_nxt     = cur_r;
            info_x_nxt = rd_data;
          end
          if (path_cnt_r != '0) begin
            comp_idx_nxt = '0;
            state_nxt    = ST_COMPRESS;
          end else begin
            find_done = 1'b1;
          end
        end else begin
          // Follow the link and remember the node for compression.
          if (path_cnt_r < PATH_CNT_W'(PATH_DEPTH)) begin
            path_push    = 1'b1;
            path_cnt_nxt = path_cnt_r + 1'b1;
          end
          cur_nxt = rd_data.parent;
          rd_addr = rd_data.parent;
        end
      end
      ST_COMPRESS: begin
        // Point one walked node straight at the root.
        wr_req.en    = 1'b1;
        wr_req.addr  = path_r[comp_idx_r];
        wr_req.data  = phase_y_r ? info_y_r : info_x_r;
        comp_idx_nxt = comp_idx_r + 1'b1;
        if ((PATH_CNT_W'(comp_idx_r) + PATH_CNT_W'(1)) == path_cnt_r) begin
          find_done = 1'b1;
        end
      end
      ST_MERGE_LOSE: begin
        // Hang the losing root under the winner.
        wr_req.en          = 1'b1;
        wr_req.addr        = lose_idx;
        wr_req.data        = win_is_y ? info_x_r : info_y_r;
        wr_req.data.parent = win_idx;
        state_nxt          = ST_MERGE_WIN;
      end
      ST_MERGE_WIN: begin
        wr_req.en          = 1'b1;
        wr_req.addr        = win_idx;
        wr_req.data.parent = win_idx;
        wr_req.data.count  = merged_count;
        wr_req.data.low    = merged_low;
        wr_req.data.high   = merged_high;
        state_nxt          = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // End of a find: start on y, or move on to the merge or the result.
    if (find_done) begin
      if (!phase_y_r) begin
        phase_y_nxt  = 1'b1;
        cur_nxt      = y_r;
        rd_addr      = y_r;
        path_cnt_nxt = '0;
        state_nxt    = ST_CHECK;
      end else if ((op_r == dsmm_pkg::OP_UNITE) && (rx_r != end_root)) begin
        state_nxt = ST_MERGE_LOSE;
      end else begin
        state_nxt = ST_RESULT;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      sweep_cnt_r   <= '0;
      sweep_clear_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      sweep_clear_r <= sweep_clear_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, walk and output payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    cur_r      <= cur_nxt;
    phase_y_r  <= phase_y_nxt;
    path_cnt_r <= path_cnt_nxt;
    comp_idx_r <= comp_idx_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    info_x_r   <= info_x_nxt;
    info_y_r   <= info_y_nxt;
    if (path_push) begin
      path_r[path_cnt_r[PATH_IDX_W-1:0]] <= cur_r;
    end
    if (out_load) begin
      out_root_x_r   <= res_root_x;
      out_root_y_r   <= res_root_y;
      out_same_set_r <= res_same;
      out_set_min_r  <= res_min;
      out_set_max_r  <= res_max;
      out_set_size_r <= res_size;
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_root_x   = out_root_x_r;
  assign out_root_y   = out_root_y_r;
  assign out_same_set = out_same_set_r;
  assign out_set_min  = out_set_min_r;
  assign out_set_max  = out_set_max_r;
  assign out_set_size = out_set_size_r;

  // A walk never runs deeper than the path store.
  `ASSERT_IMPLIES(a_path_room, (state_r == ST_CHECK) && (rd_data.parent != cur_r), path_cnt_r < PATH_CNT_W'(PATH_DEPTH))
  // Once an item is taken, no further item is taken in the next cycle.
  `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
  // The sweep writes an entry in every cycle.
  `ASSERT_IMPLIES(a_sweep_writes, state_r == ST_SWEEP, wr_req.en)
  // A delivered set is never empty and its bounds are ordered.
  `ASSERT_IMPLIES(a_out_sane, out_valid_r, (out_set_min_r <= out_set_max_r) && (out_set_size_r != '0))
  // A merging unite always reports both elements in one set.
  `ASSERT_NEXT(a_merge_joins, out_load && do_merge && (op_r == dsmm_pkg::OP_UNITE), out_same_set_r)

endmodule

>>> hdl/dsmm_table.sv
// ---------------------------------------------------------------------------
// Disjoint-set table memory
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module dsmm_table (
  input  logic                        clk,
  input  dsmm_pkg::wr_req_t           wr_req,
  input  logic [dsmm_pkg::IDX_W-1:0]  rd_addr,
  output dsmm_pkg::entry_t            rd_data
);

  dsmm_pkg::entry_t mem_r [dsmm_pkg::NUM_ELEMENTS];
  dsmm_pkg::entry_t rd_data_r;

  // Write port; a read of the address being written returns the old entry.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem_r[wr_req.addr] <= wr_req.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> test/tb_disjoint_set_min_max_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the disjoint-set min/max unit
// Drives query, unite and clear operations through the input channel and
// checks every result against an in-bench union-find table that tracks the
// root, size, smallest and largest element of each set. Both channels idle
// and stall at random, and one phase holds the results back until the unit
// fills up and stalls its input.
// ---------------------------------------------------------------------------
module tb_disjoint_set_min_max_unit;

  localparam int IDX_W        = dsmm_pkg::IDX_W;
  localparam int CNT_W        = dsmm_pkg::CNT_W;
  localparam int NUM_ELEMENTS = dsmm_pkg::NUM_ELEMENTS;

  // The spare opcode, which the unit treats as a query.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 650;
  localparam int CHUNK_ITEMS    = 40;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One result as the unit should report it.
  typedef struct packed {
    idx_t root_x;
    idx_t root_y;
    logic same_set;
    idx_t set_min;
    idx_t set_max;
    cnt_t set_size;
  } set_info_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = dsmm_pkg::OP_QUERY;
  idx_t       in_elem_x = '0;
  idx_t       in_elem_y = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  idx_t       out_root_x;
  idx_t       out_root_y;
  logic       out_same_set;
  idx_t       out_set_min;
  idx_t       out_set_max;
  cnt_t       out_set_size;

  // Shadow copy of the unit's table.
  idx_t link_mem [NUM_ELEMENTS];
  cnt_t size_mem [NUM_ELEMENTS];
  idx_t low_mem  [NUM_ELEMENTS];
  idx_t high_mem [NUM_ELEMENTS];

  set_info_t pending_set_info[$];
  int        error_count     = 0;
  int        items_accepted  = 0;
  int        results_seen    = 0;
  int        idle_cycles     = 0;
  bit        in_gaps_on      = 1'b0;
  bit        out_stalls_on   = 1'b0;
  int        out_hold_cycles = 0;
  int        out_gap_left    = 0;

  disjoint_set_min_max_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_elem_x    (in_elem_x),
    .in_elem_y    (in_elem_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_root_x   (out_root_x),
    .out_root_y   (out_root_y),
    .out_same_set (out_same_set),
    .out_set_min  (out_set_min),
    .out_set_max  (out_set_max),
    .out_set_size (out_set_size)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Union-find predictor
  // -------------------------------------------------------------------------

  // Every element back to a singleton set.
  function automatic void make_singletons();
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      link_mem[i] = idx_t'(i);
      size_mem[i] = cnt_t'(1);
      low_mem[i]  = idx_t'(i);
      high_mem[i] = idx_t'(i);
    end
  endfunction

  // Walk up to the root, then point every node on the path straight at it.
  function automatic idx_t find_and_flatten(idx_t e);
    idx_t r;
    idx_t cur;
    idx_t nxt;
    int   steps;
    r = e;
    steps = 0;
    while (link_mem[r] != r && steps < NUM_ELEMENTS) begin
      r = link_mem[r];
      steps++;
    end
    cur = e;
    steps = 0;
    while (cur != r && steps < NUM_ELEMENTS) begin
      nxt = link_mem[cur];
      link_mem[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  // Apply one operation to the shadow table and return the expected result.
  function automatic set_info_t predict_set_info(logic [1:0] op, idx_t x, idx_t y);
    idx_t      rx;
    idx_t      ry;
    idx_t      swap;
    set_info_t res;
    if (op == dsmm_pkg::OP_CLEAR) begin
      make_singletons();
    end else if (op == dsmm_pkg::OP_UNITE) begin
      rx = find_and_flatten(x);
      ry = find_and_flatten(y);
      if (rx != ry) begin
        // The larger set's root wins; on a tie x's root stays on top.
        if (size_mem[rx] < size_mem[ry]) begin
          swap = rx;
          rx   = ry;
          ry   = swap;
        end
        size_mem[rx] = size_mem[rx] + size_mem[ry];
        link_mem[ry] = rx;
        if (high_mem[ry] > high_mem[rx]) high_mem[rx] = high_mem[ry];
        if (low_mem[ry] < low_mem[rx]) low_mem[rx] = low_mem[ry];
      end
    end
    rx = find_and_flatten(x);
    ry = find_and_flatten(y);
    res.root_x   = rx;
    res.root_y   = ry;
    res.same_set = (rx == ry);
    res.set_min  = low_mem[rx];
    res.set_max  = high_mem[rx];
    res.set_size = size_mem[rx];
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("%0t: result %0d, %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    set_info_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_set_info.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_set_info.pop_front();
        if (out_root_x !== want.root_x)
          report_mismatch("root_x", out_root_x, want.root_x);
        if (out_root_y !== want.root_y)
          report_mismatch("root_y", out_root_y, want.root_y);
        if (out_same_set !== want.same_set)
          report_mismatch("same_set", out_same_set, want.same_set);
        if (out_set_min !== want.set_min)
          report_mismatch("set_min", out_set_min, want.set_min);
        if (out_set_max !== want.set_max)
          report_mismatch("set_max", out_set_max, want.set_max);
        if (out_set_size !== want.set_size)
          report_mismatch("set_size", out_set_size, want.set_size);
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run once no transfer has happened for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: a long hold-off when asked, otherwise random stalls
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_hold_cycles > 0) begin
      out_ready = 1'b0;
      out_hold_cycles--;
    end else if (out_gap_left > 0) begin
      out_ready = 1'b0;
      out_gap_left--;
    end else if (out_stalls_on && $urandom_range(0, 9) == 0) begin
      out_ready = 1'b0;
      out_gap_left = $urandom_range(1, 13) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------

  // Offer one item from a falling edge and hold it until its transfer. Valid
  // stays high afterwards unless a gap follows or the caller drains.
  task automatic send_item(logic [1:0] op, idx_t x, idx_t y);
    set_info_t expected;
    in_valid  = 1'b1;
    in_opcode = op;
    in_elem_x = x;
    in_elem_y = y;
    do @(posedge clk); while (!in_ready);
    expected = predict_set_info(op, x, y);
    pending_set_info = {pending_set_info, expected};
    items_accepted++;
    @(negedge clk);
    if (in_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_set_info.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random operation over a window of elements, so that sets grow together.
  task automatic send_random_op(idx_t pool_base, int pool_span);
    int         pick;
    logic [1:0] op;
    idx_t       x;
    idx_t       y;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = dsmm_pkg::OP_UNITE;
    else if (pick < 88) op = dsmm_pkg::OP_QUERY;
    else if (pick < 97) op = OP_SPARE;
    else                op = dsmm_pkg::OP_CLEAR;
    if ($urandom_range(0, 3) != 0) x = pool_base + idx_t'($urandom_range(0, pool_span - 1));
    else                           x = idx_t'($urandom_range(0, NUM_ELEMENTS - 1));
    if ($urandom_range(0, 3) != 0) y = pool_base + idx_t'($urandom_range(0, pool_span - 1));
    else                           y = idx_t'($urandom_range(0, NUM_ELEMENTS - 1));
    send_item(op, x, y);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  task automatic apply_reset();
    make_singletons();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  endtask

  // Fresh table: every element is its own set, including the spare opcode.
  task automatic test_reset_state();
    send_item(dsmm_pkg::OP_QUERY, idx_t'(0), idx_t'(0));
    send_item(dsmm_pkg::OP_QUERY, idx_t'(NUM_ELEMENTS - 1), idx_t'(NUM_ELEMENTS - 1));
    send_item(dsmm_pkg::OP_QUERY, idx_t'(0), idx_t'(NUM_ELEMENTS - 1));
    send_item(OP_SPARE, idx_t'(5), idx_t'(9));
    wait_for_results();
  endtask

  // Merging rules: extremes, ties, larger set winning, unite within one set
  // and a path that needs flattening.
  task automatic test_unite_rules();
    send_item(dsmm_pkg::OP_UNITE, idx_t'(0), idx_t'(NUM_ELEMENTS - 1));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(NUM_ELEMENTS - 1), idx_t'(0));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(512), idx_t'(0));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(3), idx_t'(4));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(5), idx_t'(6));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(3), idx_t'(5));
    send_item(dsmm_pkg::OP_QUERY, idx_t'(6), idx_t'(4));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(6), idx_t'(512));
    send_item(OP_SPARE, idx_t'(NUM_ELEMENTS - 1), idx_t'(4));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(4), idx_t'(4));
    wait_for_results();
  endtask

  // A clear reports fresh singletons, whether or not x equals y.
  task automatic test_clear();
    send_item(dsmm_pkg::OP_CLEAR, idx_t'(7), idx_t'(7));
    send_item(dsmm_pkg::OP_QUERY, idx_t'(0), idx_t'(NUM_ELEMENTS - 1));
    send_item(dsmm_pkg::OP_UNITE, idx_t'(1), idx_t'(2));
    send_item(dsmm_pkg::OP_CLEAR, idx_t'(NUM_ELEMENTS - 1), idx_t'(0));
    wait_for_results();
  endtask

  // Build a binomial tree by merging equal-sized roots level by level, which
  // gives paths as long as union by size allows, then query its deep nodes.
  task automatic build_deep_tree(int levels);
    idx_t base;
    int   span;
    span = 1 << levels;
    base = idx_t'($urandom_range(0, (NUM_ELEMENTS >> levels) - 1) << levels);
    send_item(dsmm_pkg::OP_CLEAR, idx_t'($urandom), idx_t'($urandom));
    for (int lvl = 0; lvl < levels; lvl++) begin
      for (int i = 0; i < span; i += 2 << lvl) begin
        if ($urandom_range(0, 3) == 0)
          send_item(dsmm_pkg::OP_UNITE, base + idx_t'(i + (1 << lvl)), base + idx_t'(i));
        else
          send_item(dsmm_pkg::OP_UNITE, base + idx_t'(i), base + idx_t'(i + (1 << lvl)));
      end
    end
    send_item(dsmm_pkg::OP_QUERY, base + idx_t'(span - 1), base + idx_t'(span - 2));
    repeat (5)
      send_item($urandom_range(0, 1) ? dsmm_pkg::OP_QUERY : OP_SPARE,
                base + idx_t'($urandom_range(0, span - 1)),
                base + idx_t'($urandom_range(0, span - 1)));
  endtask

  task automatic test_chunk(idx_t pool_base, int pool_span, int count);
    repeat (count) send_random_op(pool_base, pool_span);
  endtask

  // Random mix of deep trees and operation chunks, idling toggled per chunk.
  task automatic test_random_mix();
    int stop_at;
    stop_at = items_accepted + RANDOM_ITEMS;
    while (items_accepted < stop_at) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        build_deep_tree($urandom_range(3, 7));
      end else begin
        test_chunk(idx_t'($urandom), 8 << $urandom_range(0, 3), CHUNK_ITEMS);
      end
    end
    wait_for_results();
  endtask

  // Hold results back long enough for the unit to fill and stall its input,
  // then pause the sender until everything has come out.
  task automatic test_backpressure();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    out_hold_cycles = 500;
    test_chunk(idx_t'($urandom), 16, 30);
    wait_for_results();
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    test_chunk(idx_t'($urandom), 32, 60);
    wait_for_results();
  endtask

  initial begin
    apply_reset();
    test_reset_state();
    test_unite_rules();
    test_clear();
    test_random_mix();
    test_backpressure();
    test_steady_stream();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_set_info.size() != 0)
      report_mismatch("results never arrived", 0, pending_set_info.size());
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dsmm_pkg.sv
hdl/dsmm_table.sv
hdl/disjoint_set_min_max_unit.sv
test/tb_disjoint_set_min_max_unit.sv
